FILE: hw/rtl/xtea_pkg.sv
package xtea_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [3:0] key_t;
    typedef logic [1:0] key_sel_t;

    typedef struct packed {
        logic  op;
        word_t v0;
        word_t v1;
    } stage_t;

    localparam word_t DELTA = 32'h9E3779B9;

    localparam key_sel_t KEY_WORD0 = 2'd0;
    localparam key_sel_t KEY_WORD1 = 2'd1;
    localparam key_sel_t KEY_WORD2 = 2'd2;
    localparam key_sel_t KEY_WORD3 = 2'd3;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // running sum after n delta steps, mod 2^32
    function automatic word_t round_sum(input int unsigned n);
        logic [63:0] prod;
        prod = 64'(n) * 64'(DELTA);
        return prod[31:0];
    endfunction

    function automatic word_t mix(input word_t v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

FILE: hw/rtl/xtea_block_cipher.sv
// XTEA cipher on 64-bit blocks with a 128-bit key in four key registers.
// A word is taken with start at any edge where busy is low; busy never
// rises, so one word can enter every cycle. Each round is two register
// stages (one half round each); a result leaves the last round on
// result_lo and result_hi with result_valid, in order, one per accepted
// word. Results cannot be held off and must be taken in the cycle they
// are shown. Key writes are registered and must not overlap words in
// flight.
module xtea_block_cipher import xtea_pkg::*; #(
    parameter int ROUNDS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  key_sel_t cfg_index,
    input  word_t    cfg_data,
    input  logic     start,
    output logic     busy,
    input  logic     op,
    input  word_t    block_lo,
    input  word_t    block_hi,
    output logic     result_valid,
    output word_t    result_lo,
    output word_t    result_hi
);

    localparam int LATENCY = 2 * ROUNDS;

    key_t key_reg;
    key_t key_next;

    logic   valid_chain [0:ROUNDS];
    stage_t data_chain  [0:ROUNDS];

    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                KEY_WORD0: key_next[KEY_WORD0] = cfg_data;
                KEY_WORD1: key_next[KEY_WORD1] = cfg_data;
                KEY_WORD2: key_next[KEY_WORD2] = cfg_data;
                KEY_WORD3: key_next[KEY_WORD3] = cfg_data;
                default:   key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= '0;
        else
            key_reg <= key_next;
    end

    assign busy = 1'b0;

    assign valid_chain[0] = start && !busy;
    assign data_chain[0]  = '{op: op, v0: block_lo, v1: block_hi};

    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_round
        xtea_round #(
            .ROUNDS (ROUNDS),
            .IDX    (i)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .keys      (key_reg),
            .in_valid  (valid_chain[i]),
            .in_word   (data_chain[i]),
            .out_valid (valid_chain[i + 1]),
            .out_word  (data_chain[i + 1])
        );
    end

    assign result_valid = valid_chain[ROUNDS];
    assign result_lo    = data_chain[ROUNDS].v0;
    assign result_hi    = data_chain[ROUNDS].v1;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, LATENCY))
        else $error("result without a word accepted at the pipeline depth");

endmodule

FILE: hw/rtl/xtea_round.sv
module xtea_round import xtea_pkg::*; #(
    parameter int ROUNDS = 32,
    parameter int IDX    = 0
) (
    input  logic   clk,
    input  logic   rst_n,
    input  key_t   keys,
    input  logic   in_valid,
    input  stage_t in_word,
    output logic   out_valid,
    output stage_t out_word
);

    localparam word_t ENC_A = round_sum(IDX);
    localparam word_t ENC_B = round_sum(IDX + 1);
    localparam word_t DEC_A = round_sum(ROUNDS - IDX);
    localparam word_t DEC_B = round_sum(ROUNDS - IDX - 1);

    localparam key_sel_t ENC_A_SEL = ENC_A[1:0];
    localparam key_sel_t ENC_B_SEL = ENC_B[12:11];
    localparam key_sel_t DEC_A_SEL = DEC_A[12:11];
    localparam key_sel_t DEC_B_SEL = DEC_B[1:0];

    logic   mid_valid_reg;
    stage_t mid_reg;
    stage_t mid_next;
    logic   out_valid_reg;
    stage_t out_reg;
    stage_t out_next;

    word_t sum_a;
    word_t key_a;
    word_t src_a;
    word_t f_a;
    word_t sum_b;
    word_t key_b;
    word_t src_b;
    word_t f_b;

    // first half: encrypt updates v0, decrypt updates v1
    always_comb
    begin
        if (in_word.op == OP_DECRYPT)
        begin
            sum_a = DEC_A;
            key_a = keys[DEC_A_SEL];
            src_a = in_word.v0;
        end
        else
        begin
            sum_a = ENC_A;
            key_a = keys[ENC_A_SEL];
            src_a = in_word.v1;
        end
        f_a = mix(src_a) ^ (sum_a + key_a);
        mid_next = in_word;
        if (in_word.op == OP_DECRYPT)
            mid_next.v1 = in_word.v1 - f_a;
        else
            mid_next.v0 = in_word.v0 + f_a;
    end

    // second half: encrypt updates v1, decrypt updates v0
    always_comb
    begin
        if (mid_reg.op == OP_DECRYPT)
        begin
            sum_b = DEC_B;
            key_b = keys[DEC_B_SEL];
            src_b = mid_reg.v1;
        end
        else
        begin
            sum_b = ENC_B;
            key_b = keys[ENC_B_SEL];
            src_b = mid_reg.v0;
        end
        f_b = mix(src_b) ^ (sum_b + key_b);
        out_next = mid_reg;
        if (mid_reg.op == OP_DECRYPT)
            out_next.v0 = mid_reg.v0 - f_b;
        else
            out_next.v1 = mid_reg.v1 + f_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= in_valid;
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $past(mid_valid_reg))
        else $error("second half valid without first half");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.op == $past(mid_reg.op)))
        else $error("op changed between half rounds");

endmodule
